### hw/rtl/rlre_pkg.sv
package rlre_pkg;

    // Default geometry of the log ring
    localparam int LOG_DEPTH_DEF = 32;
    localparam int DATA_BITS_DEF = 64;

    // Fixed field widths
    localparam int INDEX_W  = 32;
    localparam int TERM_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FUNC_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Shift of the fixed-point reciprocal used for the slot reduction
    localparam int RECIP_SHIFT = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_STABLE = 2'd1,
        FUNC_COMMIT = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_BEHIND        = 3'd1,
        ST_BAD_INDEX     = 3'd2,
        ST_BEYOND_STABLE = 3'd3,
        ST_TOO_FAR       = 3'd4
    } status_t;

    // Register indexes on the configuration port (paddr[2])
    localparam logic [0:0] REG_CURRENT_TERM = 1'b0;
    localparam logic [0:0] REG_MULTICAST    = 1'b1;

endpackage

### hw/rtl/rlre_slot_mod.sv
module rlre_slot_mod #(
    parameter int LOG_DEPTH = rlre_pkg::LOG_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                step,
    input  logic [rlre_pkg::INDEX_W-2:0]        index,
    output logic [$clog2(LOG_DEPTH)-1:0]        slot
);

    localparam int SLOT_W  = $clog2(LOG_DEPTH);
    localparam int MAG_W   = rlre_pkg::INDEX_W - 1;
    localparam int RECIP_W = rlre_pkg::RECIP_SHIFT;
    localparam int PROD_W  = MAG_W + RECIP_W;

    // floor(2^32 / depth): the quotient estimate is at most one low
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << rlre_pkg::RECIP_SHIFT) / LOG_DEPTH);
    localparam logic [MAG_W-1:0]   DEPTH_M = MAG_W'(LOG_DEPTH);
    localparam logic [SLOT_W:0]    DEPTH_R = (SLOT_W + 1)'(LOG_DEPTH);

    logic [PROD_W-1:0] prod_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [MAG_W-1:0]  quot;
    logic [MAG_W-1:0]  quot_depth;
    logic [MAG_W-1:0]  diff;
    logic [SLOT_W:0]   rem;
    logic [SLOT_W:0]   rem_fix;

    always_comb
    begin
        quot       = prod_reg[PROD_W-1:rlre_pkg::RECIP_SHIFT];
        quot_depth = MAG_W'(quot * DEPTH_M);
        diff       = mag_reg - quot_depth;
        // remainder estimate stays below twice the depth
        rem        = diff[SLOT_W:0];
        rem_fix    = (rem >= DEPTH_R) ? (rem - DEPTH_R) : rem;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            prod_reg <= PROD_W'(index) * PROD_W'(RECIP);
            mag_reg  <= index;
            slot_reg <= rem_fix[SLOT_W-1:0];
        end
    end

    assign slot = slot_reg;

endmodule

### hw/rtl/replicated_log_ring_engine.sv
// Replicated log ring engine: a consensus log held in a ring of LOG_DEPTH slots.
// Items arrive on the item channel (func, log_index, entry_term, entry_data) with
// item_valid/item_ready; results leave on the result channel with
// result_valid/result_ready. One item is worked at a time; item_ready is high
// whenever the engine is idle, even while the final result of the previous item
// still sits in the output register waiting for its transfer.
// From item transfer to final result: an append passes S_SLOT and S_ACCESS, a term
// query S_SLOT, S_ACCESS and S_QDATA (no S_QDATA for index minus one or an index
// out of range), advance-stable walks in S_WALK, and commit checks in S_CCHECK and,
// unless refused or not ahead, issues its entry reads in S_COMMIT. These steps are
// set by the two-stage slot reduction (index mod LOG_DEPTH through a reciprocal
// multiply), the registered slot memory read, and the walk over one slot per cycle.
// Committed entries stream out at one transfer per cycle while the receiver keeps
// result_ready high; a stall holds the output register and the pending memory
// read, and the walk pauses without losing or repeating an entry.
// Reset clears the indexes to minus one, all slot valid bits, the registers
// on the configuration port and the channel control. Slot data and terms are not
// cleared; there is no clearing pass after reset.
// Configuration: APB-style port, current_term at 0x0, multicast_mode at 0x4.
module replicated_log_ring_engine #(
    parameter int LOG_DEPTH = rlre_pkg::LOG_DEPTH_DEF,
    parameter int DATA_BITS = rlre_pkg::DATA_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // item channel
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [rlre_pkg::FUNC_W-1:0]         func,
    input  logic signed [rlre_pkg::INDEX_W-1:0] log_index,
    input  logic [rlre_pkg::TERM_W-1:0]         entry_term,
    input  logic [DATA_BITS-1:0]                entry_data,

    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [rlre_pkg::STATUS_W-1:0]       status,
    output logic [DATA_BITS-1:0]                out_data,
    output logic [rlre_pkg::TERM_W-1:0]         out_term,
    output logic signed [rlre_pkg::INDEX_W-1:0] out_index,
    output logic                                is_entry,
    output logic                                last_of_run,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rlre_pkg::PADDR_W-1:0]        paddr,
    input  logic [rlre_pkg::PDATA_W-1:0]        pwdata,
    output logic [rlre_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int SLOT_W  = $clog2(LOG_DEPTH);
    localparam int STEP_W  = $clog2(LOG_DEPTH + 1);
    localparam int IDX_W   = rlre_pkg::INDEX_W;
    localparam int TERM_W  = rlre_pkg::TERM_W;

    localparam logic [SLOT_W-1:0]        SLOT_LAST  = SLOT_W'(LOG_DEPTH - 1);
    localparam logic [STEP_W-1:0]        STEP_LIMIT = STEP_W'(LOG_DEPTH);
    localparam logic signed [IDX_W:0]    SPAN_LIMIT = (IDX_W + 1)'(LOG_DEPTH);
    localparam logic signed [IDX_W-1:0]  IDX_NONE   = -32'sd1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SLOT   = 8'b0000_0010,
        S_ACCESS = 8'b0000_0100,
        S_QDATA  = 8'b0000_1000,
        S_CCHECK = 8'b0001_0000,
        S_COMMIT = 8'b0010_0000,
        S_WALK   = 8'b0100_0000,
        S_FINAL  = 8'b1000_0000
    } state_t;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    rlre_pkg::func_t             func_reg;
    logic signed [IDX_W-1:0]     idx_reg;
    logic [TERM_W-1:0]           term_in_reg;
    logic [DATA_BITS-1:0]        data_in_reg;

    logic signed [IDX_W-1:0]     last_index_reg;
    logic signed [IDX_W-1:0]     stable_index_reg;
    logic signed [IDX_W-1:0]     commit_index_reg;
    logic signed [IDX_W-1:0]     applied_index_reg;
    logic [SLOT_W-1:0]           stable_slot_reg;   // slot of stable_index + 1
    logic [SLOT_W-1:0]           applied_slot_reg;  // slot of applied_index + 1
    logic [STEP_W-1:0]           steps_reg;
    logic [LOG_DEPTH-1:0]        valid_reg;

    logic [TERM_W-1:0]           current_term_reg;
    logic                        multicast_reg;

    // slot memories, registered read
    logic [DATA_BITS-1:0]        data_mem [LOG_DEPTH];
    logic [TERM_W-1:0]           term_mem [LOG_DEPTH];
    logic [DATA_BITS-1:0]        rd_data_reg;
    logic [TERM_W-1:0]           rd_term_reg;

    // pending entry: read issued, data in rd_data_reg
    logic                        pend_valid_reg;
    logic signed [IDX_W-1:0]     pend_index_reg;

    // final result of the current item
    rlre_pkg::status_t           fin_status_reg;
    logic [TERM_W-1:0]           fin_term_reg;
    logic signed [IDX_W-1:0]     fin_index_reg;

    // output register
    logic                        res_valid_reg;
    rlre_pkg::status_t           res_status_reg;
    logic [DATA_BITS-1:0]        res_data_reg;
    logic [TERM_W-1:0]           res_term_reg;
    logic signed [IDX_W-1:0]     res_index_reg;
    logic                        res_entry_reg;
    logic                        res_last_reg;

    // ------------------------------------------------------------------
    // Control signals
    // ------------------------------------------------------------------
    logic                        item_xfer;
    logic                        cfg_write;
    logic [SLOT_W-1:0]           slot;
    logic                        slot_step;

    logic                        out_free;
    logic                        pend_move;
    logic                        commit_more;
    logic                        commit_issue;
    logic                        walk_go;

    logic                        append_ok;
    logic                        mem_we;
    logic                        term_re;

    logic                        ck_not_ahead;
    logic                        ck_beyond;
    logic                        ck_too_far;
    logic signed [IDX_W:0]       commit_span;

    logic                        query_direct;
    logic                        query_bad;

    assign item_ready = (state_reg == S_IDLE);
    assign item_xfer  = item_valid && item_ready;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // index mod depth, two stages: product at the transfer, slot in S_SLOT
    assign slot_step = item_xfer || (state_reg == S_SLOT);

    rlre_slot_mod #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_slot_mod (
        .clk   (clk),
        .step  (slot_step),
        .index (log_index[IDX_W-2:0]),
        .slot  (slot)
    );

    always_comb
    begin
        out_free     = !res_valid_reg || result_ready;
        pend_move    = pend_valid_reg && out_free;
        commit_more  = (applied_index_reg != commit_index_reg);
        commit_issue = (state_reg == S_COMMIT) && commit_more
                       && (!pend_valid_reg || pend_move);

        walk_go = (stable_index_reg < last_index_reg) && (steps_reg != STEP_LIMIT)
                  && valid_reg[stable_slot_reg];

        append_ok = !(commit_index_reg > idx_reg) && (idx_reg >= 0);
        mem_we    = (state_reg == S_ACCESS) && (func_reg == rlre_pkg::FUNC_APPEND)
                    && append_ok;

        query_direct = (idx_reg == IDX_NONE);
        query_bad    = (idx_reg < IDX_NONE) || (idx_reg > last_index_reg);
        term_re      = (state_reg == S_ACCESS) && (func_reg == rlre_pkg::FUNC_QUERY)
                       && !query_direct && !query_bad;

        commit_span  = (IDX_W + 1)'(idx_reg) - (IDX_W + 1)'(applied_index_reg);
        ck_not_ahead = (idx_reg <= commit_index_reg);
        ck_beyond    = !multicast_reg && (idx_reg > stable_index_reg);
        ck_too_far   = (commit_span > SPAN_LIMIT);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    unique case (rlre_pkg::func_t'(func))
                        rlre_pkg::FUNC_APPEND: state_next = S_SLOT;
                        rlre_pkg::FUNC_QUERY:  state_next = S_SLOT;
                        rlre_pkg::FUNC_STABLE: state_next = S_WALK;
                        rlre_pkg::FUNC_COMMIT: state_next = S_CCHECK;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_SLOT:   state_next = S_ACCESS;
            S_ACCESS: state_next = term_re ? S_QDATA : S_FINAL;
            S_QDATA:  state_next = S_FINAL;
            S_CCHECK:
            begin
                if (ck_not_ahead || ck_beyond || ck_too_far)
                    state_next = S_FINAL;
                else
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!commit_more && (!pend_valid_reg || pend_move))
                    state_next = S_FINAL;
            end
            S_WALK:
            begin
                if (!walk_go)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // capture the item
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            func_reg    <= rlre_pkg::func_t'(func);
            idx_reg     <= log_index;
            term_in_reg <= entry_term;
            data_in_reg <= entry_data;
        end
    end

    // ------------------------------------------------------------------
    // Log indexes, walk pointers and valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg    <= IDX_NONE;
            stable_index_reg  <= IDX_NONE;
            commit_index_reg  <= IDX_NONE;
            applied_index_reg <= IDX_NONE;
            stable_slot_reg   <= '0;
            applied_slot_reg  <= '0;
            steps_reg         <= '0;
            valid_reg         <= '0;
            pend_valid_reg    <= 1'b0;
        end
        else
        begin
            if (item_xfer)
                steps_reg <= '0;

            // append: mark the slot and raise last
            if (mem_we)
            begin
                valid_reg[slot] <= 1'b1;
                if (last_index_reg < idx_reg)
                    last_index_reg <= idx_reg;
            end

            // advance stable over one valid slot per cycle
            if ((state_reg == S_WALK) && walk_go)
            begin
                stable_index_reg <= stable_index_reg + 32'sd1;
                stable_slot_reg  <= (stable_slot_reg == SLOT_LAST) ? '0
                                    : stable_slot_reg + SLOT_W'(1);
                steps_reg        <= steps_reg + STEP_W'(1);
            end

            // take the new commit point
            if ((state_reg == S_CCHECK) && !ck_not_ahead && !ck_beyond && !ck_too_far)
                commit_index_reg <= idx_reg;

            // issue one entry read per cycle while pend is free, drop its valid bit
            if (commit_issue)
            begin
                valid_reg[applied_slot_reg] <= 1'b0;
                applied_index_reg           <= applied_index_reg + 32'sd1;
                applied_slot_reg            <= (applied_slot_reg == SLOT_LAST) ? '0
                                               : applied_slot_reg + SLOT_W'(1);
                pend_valid_reg              <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_issue)
            pend_index_reg <= applied_index_reg + 32'sd1;
    end

    // ------------------------------------------------------------------
    // Slot memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            data_mem[slot] <= data_in_reg;
        if (commit_issue)
            rd_data_reg <= data_mem[applied_slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            term_mem[slot] <= term_in_reg;
        if (term_re)
            rd_term_reg <= term_mem[slot];
    end

    // ------------------------------------------------------------------
    // Final result of the item
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_ACCESS:
            begin
                fin_term_reg <= '0;
                if (func_reg == rlre_pkg::FUNC_APPEND)
                begin
                    fin_index_reg <= last_index_reg;
                    if (commit_index_reg > idx_reg)
                        fin_status_reg <= rlre_pkg::ST_BEHIND;
                    else if (idx_reg < 0)
                        fin_status_reg <= rlre_pkg::ST_BAD_INDEX;
                    else
                    begin
                        fin_status_reg <= rlre_pkg::ST_OK;
                        if (last_index_reg < idx_reg)
                            fin_index_reg <= idx_reg;
                    end
                end
                else
                begin
                    fin_index_reg <= last_index_reg;
                    if (query_direct)
                    begin
                        fin_status_reg <= rlre_pkg::ST_OK;
                        fin_term_reg   <= current_term_reg;
                    end
                    else if (query_bad)
                        fin_status_reg <= rlre_pkg::ST_BAD_INDEX;
                    else
                        fin_status_reg <= rlre_pkg::ST_OK;
                end
            end
            S_QDATA:
            begin
                fin_term_reg <= rd_term_reg;
            end
            S_CCHECK:
            begin
                fin_term_reg <= '0;
                if (ck_not_ahead)
                begin
                    fin_status_reg <= rlre_pkg::ST_OK;
                    fin_index_reg  <= commit_index_reg;
                end
                else if (ck_beyond)
                begin
                    fin_status_reg <= rlre_pkg::ST_BEYOND_STABLE;
                    fin_index_reg  <= commit_index_reg;
                end
                else if (ck_too_far)
                begin
                    fin_status_reg <= rlre_pkg::ST_TOO_FAR;
                    fin_index_reg  <= commit_index_reg;
                end
                else
                begin
                    fin_status_reg <= rlre_pkg::ST_OK;
                    fin_index_reg  <= idx_reg;
                end
            end
            S_WALK:
            begin
                fin_term_reg   <= '0;
                fin_status_reg <= rlre_pkg::ST_OK;
                if (!walk_go)
                    fin_index_reg <= stable_index_reg;
            end
            default:
            begin
                fin_term_reg <= fin_term_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: entry results first, then the final result
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (pend_move || ((state_reg == S_FINAL) && out_free))
            res_valid_reg <= 1'b1;
        else if (result_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            res_status_reg <= rlre_pkg::ST_OK;
            res_data_reg   <= rd_data_reg;
            res_term_reg   <= '0;
            res_index_reg  <= pend_index_reg;
            res_entry_reg  <= 1'b1;
            res_last_reg   <= 1'b0;
        end
        else if ((state_reg == S_FINAL) && out_free)
        begin
            res_status_reg <= fin_status_reg;
            res_data_reg   <= '0;
            res_term_reg   <= fin_term_reg;
            res_index_reg  <= fin_index_reg;
            res_entry_reg  <= 1'b0;
            res_last_reg   <= 1'b1;
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign out_data     = res_data_reg;
    assign out_term     = res_term_reg;
    assign out_index    = res_index_reg;
    assign is_entry     = res_entry_reg;
    assign last_of_run  = res_last_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_term_reg <= '0;
            multicast_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                rlre_pkg::REG_CURRENT_TERM: current_term_reg <= pwdata;
                rlre_pkg::REG_MULTICAST:    multicast_reg    <= pwdata[0];
                default:                    multicast_reg    <= multicast_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rlre_pkg::REG_CURRENT_TERM: prdata = current_term_reg;
            rlre_pkg::REG_MULTICAST:    prdata = {{(rlre_pkg::PDATA_W - 1){1'b0}}, multicast_reg};
            default:                    prdata = '0;
        endcase
    end

endmodule

### bench/replicated_log_ring_engine_test.sv
`timescale 1ns / 100ps

module replicated_log_ring_engine_test;

    import rlre_pkg::*;

    localparam int DEPTH       = LOG_DEPTH_DEF;
    localparam int DBITS       = DATA_BITS_DEF;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int HOLD_OFF    = 400;
    localparam int DIR_ROWS    = 25;

    // One operation offered on the item channel
    typedef struct packed {
        func_t             op;
        logic [31:0]       idx;
        logic [31:0]       term;
        logic [DBITS-1:0]  data;
    } log_op_t;

    // One transfer on the result channel
    typedef struct packed {
        status_t           st;
        logic [DBITS-1:0]  data;
        logic [31:0]       term;
        logic [31:0]       ix;
        logic              entry;
        logic              last;
    } log_result_t;

    // Directed row: the operation, and where typed is set, its final result
    typedef struct {
        func_t             op;
        int                ix;
        logic [31:0]       term;
        logic [DBITS-1:0]  data;
        bit                typed;
        status_t           st;
        logic [31:0]       wterm;
        int                wix;
    } dir_row_t;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    logic [FUNC_W-1:0]   func         = FUNC_APPEND;
    logic signed [31:0]  log_index    = '0;
    logic [31:0]         entry_term   = '0;
    logic [DBITS-1:0]    entry_data   = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [DBITS-1:0]    out_data;
    logic [31:0]         out_term;
    logic signed [31:0]  out_index;
    logic                is_entry;
    logic                last_of_run;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Shadow copy of the log: ring contents, indexes and configuration
    logic [DBITS-1:0]    ring_data [DEPTH];
    logic [31:0]         ring_term [DEPTH];
    bit                  ring_valid [DEPTH];
    bit                  ring_seen [DEPTH];   // slot written at least once since reset
    int                  last_ix    = -1;
    int                  stable_ix  = -1;
    int                  commit_ix  = -1;
    int                  applied_ix = -1;
    logic [31:0]         cfg_term   = '0;
    bit                  cfg_mcast  = 1'b0;

    log_result_t         due_results [$];
    dir_row_t            dir_rows [DIR_ROWS];
    int                  mismatch_count    = 0;
    int                  cycle_count       = 0;
    int                  send_calm         = 0;
    bit                  hold_off_request  = 1'b0;
    int                  hold_off_left     = 0;
    int                  ready_calm        = 0;
    int                  ready_stall       = 0;

    replicated_log_ring_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .log_index    (log_index),
        .entry_term   (entry_term),
        .entry_data   (entry_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .out_data     (out_data),
        .out_term     (out_term),
        .out_index    (out_index),
        .is_entry     (is_entry),
        .last_of_run  (last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Queue one expected result transfer
    task automatic due(input status_t st, input logic [DBITS-1:0] data,
                       input logic [31:0] term, input int ix, input bit entry, input bit last);
        due_results.push_back('{st, data, term, ix, entry, last});
    endtask

    // Apply one accepted operation to the shadow log and queue what it emits
    task automatic apply_log_op(input log_op_t op);
        int     ix;
        int     slot;
        int     steps;
        longint nxt;
        ix = op.idx;
        case (op.op)
            FUNC_APPEND:
            begin
                if (commit_ix > ix)
                    due(ST_BEHIND, '0, '0, last_ix, 1'b0, 1'b1);
                else if (ix < 0)
                    due(ST_BAD_INDEX, '0, '0, last_ix, 1'b0, 1'b1);
                else
                begin
                    slot = ix % DEPTH;
                    ring_data[slot]  = op.data;
                    ring_term[slot]  = op.term;
                    ring_valid[slot] = 1'b1;
                    ring_seen[slot]  = 1'b1;
                    if (last_ix < ix)
                        last_ix = ix;
                    due(ST_OK, '0, '0, last_ix, 1'b0, 1'b1);
                end
            end
            FUNC_STABLE:
            begin
                // walk over valid slots, at most one lap of the ring
                steps = 0;
                nxt = longint'(stable_ix) + 1;
                while (nxt <= longint'(last_ix) && steps < DEPTH && ring_valid[nxt % DEPTH])
                begin
                    stable_ix = int'(nxt);
                    nxt++;
                    steps++;
                end
                due(ST_OK, '0, '0, stable_ix, 1'b0, 1'b1);
            end
            FUNC_COMMIT:
            begin
                if (ix <= commit_ix)
                    due(ST_OK, '0, '0, commit_ix, 1'b0, 1'b1);
                else if (!cfg_mcast && ix > stable_ix)
                    due(ST_BEYOND_STABLE, '0, '0, commit_ix, 1'b0, 1'b1);
                else if (longint'(ix) - longint'(applied_ix) > DEPTH)
                    due(ST_TOO_FAR, '0, '0, commit_ix, 1'b0, 1'b1);
                else
                begin
                    commit_ix = ix;
                    while (applied_ix < commit_ix)
                    begin
                        applied_ix++;
                        slot = applied_ix % DEPTH;
                        due(ST_OK, ring_data[slot], '0, applied_ix, 1'b1, 1'b0);
                        ring_valid[slot] = 1'b0;
                    end
                    due(ST_OK, '0, '0, commit_ix, 1'b0, 1'b1);
                end
            end
            default:
            begin
                if (ix == -1)
                    due(ST_OK, '0, cfg_term, last_ix, 1'b0, 1'b1);
                else if (ix < -1 || ix > last_ix)
                    due(ST_BAD_INDEX, '0, '0, last_ix, 1'b0, 1'b1);
                else
                    due(ST_OK, '0, ring_term[ix % DEPTH], last_ix, 1'b0, 1'b1);
            end
        endcase
    endtask

    // Never read a slot that has not been written since reset
    function automatic bit op_is_safe(input log_op_t op);
        int ix;
        ix = op.idx;
        if (op.op == FUNC_QUERY)
            return !(ix >= 0 && ix <= last_ix && !ring_seen[ix % DEPTH]);
        if (op.op == FUNC_COMMIT && ix > commit_ix && (cfg_mcast || ix <= stable_ix)
            && longint'(ix) - longint'(applied_ix) <= DEPTH)
        begin
            for (int k = applied_ix + 1; k <= ix; k++)
                if (!ring_seen[k % DEPTH])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly in-order traffic (append next, walk, commit to stable), plus misuse
    function automatic log_op_t pick_log_op(input int stable_pct);
        log_op_t op;
        int      roll;
        int      pick;
        int      span;
        op.term = $urandom;
        op.data = {$urandom, $urandom};
        op.idx  = $urandom;
        roll = $urandom_range(99);
        pick = $urandom_range(19);
        if (roll < 40)
        begin
            op.op = FUNC_APPEND;
            if (pick < 13)
                op.idx = last_ix + 1;
            else if (pick < 16)
                op.idx = commit_ix + int'($urandom_range(8));
            else if (pick < 18)
                op.idx = commit_ix - 1 - int'($urandom_range(3));
            else
                op.idx = $urandom | 32'h8000_0000;
        end
        else if (roll < 40 + stable_pct)
            op.op = FUNC_STABLE;
        else if (roll < 65 + stable_pct)
        begin
            op.op = FUNC_COMMIT;
            if (pick < 11)
            begin
                if (stable_ix > commit_ix)
                    op.idx = commit_ix + 1 + int'($urandom_range(stable_ix - commit_ix - 1));
                else
                    op.idx = commit_ix + 1 + int'($urandom_range(3));
            end
            else if (pick < 14)
                op.idx = commit_ix - int'($urandom_range(3));
            else if (pick < 16)
                op.idx = stable_ix + 1 + int'($urandom_range(6));
            else if (pick < 18)
                op.idx = applied_ix + DEPTH + 1 + int'($urandom_range(20));
            else if (pick < 19)
                op.idx = applied_ix + DEPTH;   // widest legal commit
        end
        else
        begin
            op.op = FUNC_QUERY;
            span = (last_ix + 1 < 40) ? last_ix + 1 : 40;
            if (pick < 10)
                op.idx = last_ix - int'($urandom_range(span));
            else if (pick < 13)
                op.idx = -1;
            else if (pick < 16)
                op.idx = last_ix + 1 + int'($urandom_range(5));
            else if (pick < 18)
                op.idx = $urandom | 32'h8000_0000;
        end
        return op;
    endfunction

    // Sender idle: mostly none or short gaps, a few long ones, and calm stretches with none
    function automatic int next_send_gap();
        int roll;
        if (send_calm > 0)
        begin
            send_calm--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3)
            send_calm = $urandom_range(60, 20);
        else if (roll < 7)
            return $urandom_range(40, 12);
        else if (roll < 45)
            return $urandom_range(3, 1);
        return 0;
    endfunction

    // Offer one item, hold it until the transfer, then predict it
    task automatic issue_op(input log_op_t op, input bit typed, input log_result_t fixed);
        int gap;
        item_valid <= 1'b1;
        func       <= op.op;
        log_index  <= op.idx;
        entry_term <= op.term;
        entry_data <= op.data;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        apply_log_op(op);
        // typed rows replace the predicted final result with the hand-written one
        if (typed)
            due_results[due_results.size() - 1] = fixed;
        gap = next_send_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drive_random_ops(input int count, input int stable_pct);
        log_op_t op;
        repeat (count)
        begin
            do
                op = pick_log_op(stable_pct);
            while (!op_is_safe(op));
            issue_op(op, 1'b0, '0);
        end
    endtask

    // Drop valid, wait for every expected transfer, then let the engine settle
    task automatic drain(input int settle);
        item_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge
    task automatic write_reg(input logic [0:0] reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_CURRENT_TERM)
            cfg_term = value;
        else
            cfg_mcast = value[0];
    endtask

    task automatic flag_result(input string why, input log_result_t want,
                               input log_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s at %0t ns: want st=%0d data=%h term=%h ix=%0d entry=%b last=%b",
                     why, $time, want.st, want.data, want.term, $signed(want.ix),
                     want.entry, want.last);
            $display("    got st=%0d data=%h term=%h ix=%0d entry=%b last=%b",
                     got.st, got.data, got.term, $signed(got.ix), got.entry, got.last);
        end
    endtask

    // Result side: check each transfer against the oldest expectation, then
    // pick result_ready for the next cycle
    always @(posedge clk)
    begin : result_side
        log_result_t got;
        log_result_t want;
        logic        ready_next;
        int          roll;
        if (rst_n && result_valid && result_ready)
        begin
            got = '{status_t'(status), out_data, out_term, out_index, is_entry, last_of_run};
            if (due_results.size() == 0)
                flag_result("unexpected result", '0, got);
            else
            begin
                want = due_results.pop_front();
                if (got.st !== want.st || got.data !== want.data || got.term !== want.term
                    || got.ix !== want.ix || got.entry !== want.entry
                    || got.last !== want.last)
                    flag_result("result mismatch", want, got);
            end
        end
        // long hold-off on request so the engine fills and stalls its input
        if (hold_off_request)
        begin
            hold_off_request = 1'b0;
            hold_off_left = HOLD_OFF;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            ready_next = 1'b0;
        end
        else if (ready_calm > 0)
        begin
            ready_calm--;
            ready_next = 1'b1;
        end
        else if (ready_stall > 0)
        begin
            ready_stall--;
            ready_next = 1'b0;
        end
        else
        begin
            ready_next = 1'b1;
            roll = $urandom_range(99);
            if (roll < 4)
                ready_calm = $urandom_range(100, 30);
            else if (roll < 8)
                ready_stall = $urandom_range(48, 16);
            else if (roll < 35)
                ready_stall = $urandom_range(3, 1);
        end
        result_ready <= ready_next;
    end

    // Watchdog: end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        log_op_t     op;
        log_result_t fixed;
        // reset state first, then append/walk/commit over a short run of slots;
        // the slot of index 3 stays unwritten until row 19, so nothing reads it
        dir_rows = '{
            '{FUNC_QUERY,  -1,            32'h0, 64'h0, 1'b1, ST_OK,            32'h0, -1},
            '{FUNC_QUERY,  0,             32'h0, 64'h0, 1'b1, ST_BAD_INDEX,     32'h0, -1},
            '{FUNC_QUERY,  32'h8000_0000, 32'h0, 64'h0, 1'b1, ST_BAD_INDEX,     32'h0, -1},
            '{FUNC_QUERY,  32'h7FFF_FFFF, 32'h0, 64'h0, 1'b1, ST_BAD_INDEX,     32'h0, -1},
            '{FUNC_APPEND, -1,            32'h0, 64'h0, 1'b1, ST_BAD_INDEX,     32'h0, -1},
            '{FUNC_APPEND, 32'h8000_0000, 32'h0, 64'h0, 1'b1, ST_BEHIND,        32'h0, -1},
            '{FUNC_STABLE, 0,             32'h0, 64'h0, 1'b1, ST_OK,            32'h0, -1},
            '{FUNC_COMMIT, -1,            32'h0, 64'h0, 1'b1, ST_OK,            32'h0, -1},
            '{FUNC_COMMIT, 0,             32'h0, 64'h0, 1'b1, ST_BEYOND_STABLE, 32'h0, -1},
            '{FUNC_COMMIT, 32'h7FFF_FFFF, 32'h0, 64'h0, 1'b1, ST_BEYOND_STABLE, 32'h0, -1},
            '{FUNC_APPEND, 0, 32'h0, 64'h0, 1'b1, ST_OK, 32'h0, 0},
            '{FUNC_APPEND, 1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK, 32'h0, 1},
            '{FUNC_APPEND, 2, 32'h1234_5678, 64'h0123_4567_89AB_CDEF, 1'b1, ST_OK, 32'h0, 2},
            '{FUNC_APPEND, 4, 32'h0000_0004, 64'h8000_0000_0000_0001, 1'b1, ST_OK, 32'h0, 4},
            '{FUNC_QUERY,  1, 32'h0, 64'h0, 1'b1, ST_OK,            32'hFFFF_FFFF, 4},
            '{FUNC_QUERY,  0, 32'h0, 64'h0, 1'b1, ST_OK,            32'h0, 4},
            '{FUNC_QUERY,  5, 32'h0, 64'h0, 1'b1, ST_BAD_INDEX,     32'h0, 4},
            '{FUNC_STABLE, 0, 32'h0, 64'h0, 1'b1, ST_OK,            32'h0, 2},
            '{FUNC_COMMIT, 3, 32'h0, 64'h0, 1'b1, ST_BEYOND_STABLE, 32'h0, -1},
            '{FUNC_APPEND, 3, 32'h0000_0003, 64'h5A5A_0F0F_A5A5_F0F0, 1'b1, ST_OK, 32'h0, 4},
            '{FUNC_STABLE, 0, 32'h0, 64'h0, 1'b1, ST_OK,            32'h0, 4},
            '{FUNC_COMMIT, 2, 32'h0, 64'h0, 1'b0, ST_OK,            32'h0, 0},
            '{FUNC_APPEND, 1, 32'h0, 64'h0, 1'b1, ST_BEHIND,        32'h0, 4},
            '{FUNC_APPEND, 2, 32'h0000_0016, 64'h0000_FFFF_0000_FFFF, 1'b1, ST_OK, 32'h0, 4},
            '{FUNC_COMMIT, 4, 32'h0, 64'h0, 1'b0, ST_OK,            32'h0, 0}
        };

        // hold reset, then release it on an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            op    = '{dir_rows[i].op, dir_rows[i].ix, dir_rows[i].term, dir_rows[i].data};
            fixed = '{dir_rows[i].st, '0, dir_rows[i].wterm, dir_rows[i].wix, 1'b0, 1'b1};
            issue_op(op, dir_rows[i].typed, fixed);
        end

        // in-order commits gated by stable, largest term for the minus-one query
        drain(8);
        write_reg(REG_CURRENT_TERM, 32'hFFFF_FFFF);
        write_reg(REG_MULTICAST, 32'd0);
        drive_random_ops(90, 15);

        // multicast on; start with a long receiver hold-off while items keep coming
        drain(8);
        write_reg(REG_CURRENT_TERM, 32'd0);
        write_reg(REG_MULTICAST, 32'd1);
        hold_off_request = 1'b1;
        drive_random_ops(90, 15);

        drain(8);
        write_reg(REG_CURRENT_TERM, $urandom);
        drive_random_ops(90, 15);

        // multicast off with rare stable walks, so walks and commit bursts get long
        drain(8);
        write_reg(REG_MULTICAST, 32'd0);
        write_reg(REG_CURRENT_TERM, $urandom);
        drive_random_ops(90, 3);

        // last of all, push last_index to the top of the index range
        op = '{FUNC_APPEND, 32'h7FFF_FFFF, $urandom, {$urandom, $urandom}};
        issue_op(op, 1'b0, '0);
        op.op = FUNC_STABLE;
        issue_op(op, 1'b0, '0);
        op.op = FUNC_QUERY;
        issue_op(op, 1'b0, '0);

        drain(40);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rlre_pkg.sv
hw/rtl/rlre_slot_mod.sv
hw/rtl/replicated_log_ring_engine.sv
bench/replicated_log_ring_engine_test.sv
